// ----- rtl/forwarding_hash_table_assert.svh -----
// Assertion macros for the forwarding hash table
`ifndef FORWARDING_HASH_TABLE_ASSERT_SVH
`define FORWARDING_HASH_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, quiet while reset is held
`define FHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds through reset
`define FHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FHT_ASSERT(lbl, prop, msg)
`define FHT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/fht_pkg.sv -----
// Package: types and constants of the forwarding hash table
package fht_pkg;

  localparam int          DEPTH_LOG2_DEF = 10;
  localparam int          LOG2_W         = 5;
  localparam logic [4:0]  MIN_LOG2       = 5'd4;
  localparam logic [3:0]  CFG_RESET      = 4'd10;
  localparam logic [63:0] HASH_MULT      = 64'd2654435761;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD       = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [63:0] value;
  } slot_t;

endpackage

// ----- rtl/forwarding_hash_table.sv -----
// Top level: forwarding hash table with linear probing over one slot memory
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-------------------------------
//   command  | in_operation, in_key, in_value          | start high while busy low
//   result   | out_status, out_found_value             | out_valid, one cycle, no stall
//   config   | cfg_table_size_log2                     | cfg_valid and cfg_ready
//
// A bad key, bad operation, full table or empty lookup is answered from the idle state.
// Insert and lookup probe one slot after another: each probe is one memory read
// (registered); a lookup also compares in the shared key comparator, an insert only
// looks for a free slot. Clear sweeps the whole slot memory, then answers.
// After reset the same clearing pass runs (busy high, no result); configuration
// transactions are taken only while busy is low.
// The result receiver cannot stall: each result shows for one cycle only.
`include "forwarding_hash_table_assert.svh"

module forwarding_hash_table
  import fht_pkg::*;
#(
  parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_key,
  input  logic [63:0] in_value,
  // result channel
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [63:0] out_found_value,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_table_size_log2
);

  localparam int SLOTS = 1 << DEPTH_LOG2;
  localparam int CNT_W = DEPTH_LOG2 + 1;
  localparam int HALF  = SLOTS / 2;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic [3:0]              cfg_r;
  op_t                     op_r;
  logic [63:0]             key_r;
  logic [63:0]             value_r;
  logic [DEPTH_LOG2-1:0]   idx_r;
  logic [CNT_W-1:0]        probes_r;
  logic [DEPTH_LOG2-1:0]   sweep_r;
  logic [CNT_W-1:0]        count_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [63:0]             out_found_value_r;
  slot_t                   rd_r;

  // Slot memory: one write port, one registered read port
  slot_t                   mem [SLOTS];

  // ---------------------------------------------------------------------------
  // Capacity, home slot and compare unit
  // ---------------------------------------------------------------------------
  logic [LOG2_W-1:0]       cfg_ext;
  logic [LOG2_W-1:0]       depth_l;
  logic [LOG2_W-1:0]       active_log2;
  logic [CNT_W-1:0]        cap;
  logic [DEPTH_LOG2-1:0]   mask;
  logic [2*DEPTH_LOG2-1:0] prod;
  logic [DEPTH_LOG2-1:0]   home;
  logic                    accept;
  logic                    key_zero;
  logic                    table_full;
  logic                    table_empty;
  logic                    hit;
  logic                    last_probe;
  logic                    sweep_last;
  op_t                     in_op;

  assign cfg_ext     = LOG2_W'(cfg_r);
  assign depth_l     = LOG2_W'(DEPTH_LOG2);
  assign active_log2 = (cfg_ext < MIN_LOG2) ? MIN_LOG2 :
                       (cfg_ext > depth_l)  ? depth_l  : cfg_ext;
  assign cap         = CNT_W'(1) << active_log2;
  assign mask        = DEPTH_LOG2'(cap - CNT_W'(1));

  // Only the low bits of the product reach the slot index, so a narrow
  // multiply of the low key bits gives the same home slot.
  assign prod        = in_key[DEPTH_LOG2-1:0] * HASH_MULT[DEPTH_LOG2-1:0];
  assign home        = prod[DEPTH_LOG2-1:0] & mask;

  assign in_op       = op_t'(in_operation);
  assign accept      = start && (state_r == S_IDLE);
  assign key_zero    = (in_key == 64'd0);
  assign table_full  = {count_r, 1'b0} >= {1'b0, cap};
  assign table_empty = (count_r == '0);

  // Shared key comparator on the registered slot read
  assign hit         = rd_r.valid && (rd_r.key == key_r);
  assign last_probe  = (probes_r + CNT_W'(1)) == cap;
  assign sweep_last  = &sweep_r;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_INSERT: if (!key_zero && !table_full)  state_nxt = S_READ;
            OP_LOOKUP: if (!key_zero && !table_empty) state_nxt = S_READ;
            OP_CLEAR:  state_nxt = S_CLEAR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ: state_nxt = S_CHECK;
      S_CHECK: begin
        if (op_r == OP_INSERT) begin
          state_nxt = (!rd_r.valid || last_probe) ? S_IDLE : S_READ;
        end else begin
          state_nxt = (!rd_r.valid || hit || last_probe) ? S_IDLE : S_READ;
        end
      end
      S_CLEAR: begin
        if (sweep_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs
  // ---------------------------------------------------------------------------
  logic                  fin;
  status_t               fin_status;
  logic [63:0]           fin_value;
  logic                  probe_go;
  logic                  clear_go;
  logic                  advance;
  logic                  sweeping;
  logic                  count_inc;
  logic                  mem_we;
  logic [DEPTH_LOG2-1:0] mem_waddr;
  slot_t                 mem_wdata;

  always_comb begin
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_value  = 64'd0;
    probe_go   = 1'b0;
    clear_go   = 1'b0;
    advance    = 1'b0;
    sweeping   = 1'b0;
    count_inc  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = sweep_r;
    mem_wdata  = '0;
    unique case (state_r)
      S_INIT: begin
        sweeping = 1'b1;
        mem_we   = 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_INSERT: begin
              priority if (key_zero) begin
                fin = 1'b1; fin_status = ST_BAD;
              end else if (table_full) begin
                fin = 1'b1; fin_status = ST_FULL;
              end else begin
                probe_go = 1'b1;
              end
            end
            OP_LOOKUP: begin
              priority if (key_zero) begin
                fin = 1'b1; fin_status = ST_BAD;
              end else if (table_empty) begin
                fin = 1'b1; fin_status = ST_NOT_FOUND;
              end else begin
                probe_go = 1'b1;
              end
            end
            OP_CLEAR: clear_go = 1'b1;
            default: begin
              fin = 1'b1; fin_status = ST_BAD;
            end
          endcase
        end
      end
      S_READ: ;
      S_CHECK: begin
        if (op_r == OP_INSERT) begin
          priority if (!rd_r.valid) begin
            fin       = 1'b1;
            fin_status = ST_OK;
            mem_we    = 1'b1;
            mem_waddr = idx_r;
            mem_wdata = '{valid: 1'b1, key: key_r, value: value_r};
            count_inc = 1'b1;
          end else if (last_probe) begin
            fin = 1'b1; fin_status = ST_FULL;
          end else begin
            advance = 1'b1;
          end
        end else begin
          priority if (!rd_r.valid) begin
            fin = 1'b1; fin_status = ST_NOT_FOUND;
          end else if (hit) begin
            fin = 1'b1; fin_status = ST_FOUND; fin_value = rd_r.value;
          end else if (last_probe) begin
            fin = 1'b1; fin_status = ST_NOT_FOUND;
          end else begin
            advance = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        sweeping = 1'b1;
        mem_we   = 1'b1;
        if (sweep_last) begin
          fin = 1'b1; fin_status = ST_OK;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cfg_r       <= CFG_RESET;
      sweep_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin;
      // take a configuration transaction only while no command is in flight
      if (cfg_valid && cfg_ready) cfg_r <= cfg_table_size_log2;
      // advance the clearing pass; wrap back to zero at its end
      if (sweeping) sweep_r <= sweep_r + DEPTH_LOG2'(1);
      // drop every entry when a clear starts, count each new one
      if (clear_go) begin
        count_r <= '0;
      end else if (count_inc) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (probe_go) begin
      op_r     <= in_op;
      key_r    <= in_key;
      value_r  <= in_value;
      idx_r    <= home;
      probes_r <= '0;
    end else if (advance) begin
      // step to the next slot, wrapping inside the active capacity
      idx_r    <= (idx_r + DEPTH_LOG2'(1)) & mask;
      probes_r <= probes_r + CNT_W'(1);
    end
    if (fin) begin
      out_status_r      <= fin_status;
      out_found_value_r <= fin_value;
    end
  end

  // Slot memory: write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_r <= mem[idx_r];
  end

  assign busy            = (state_r != S_IDLE);
  assign cfg_ready       = !busy;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_value_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `FHT_ASSERT(a_result_when_idle, out_valid |-> !busy, "result shown while busy")
  `FHT_ASSERT(a_accept_progress, (start && !busy) |=> (busy || out_valid),
              "accepted transaction made no progress")
  `FHT_ASSERT(a_count_half, count_r <= CNT_W'(HALF), "entry count above half depth")
  `FHT_ASSERT(a_probe_bound, (state_r == S_CHECK) |-> (probes_r < cap),
              "probe run longer than capacity")
  `FHT_ASSERT_ALWAYS(a_write_states,
              mem_we |-> (state_r == S_CHECK || state_r == S_CLEAR || state_r == S_INIT),
              "slot write outside probe or clearing pass")

endmodule
